// File: rtl/sbfh_pkg.sv
// Shared constants and types for the segment box face hit test.
package sbfh_pkg;

    localparam int CW    = 32;            // coordinate width
    localparam int FB    = 16;            // fraction bits
    localparam int LW    = CW - 1;        // length width
    localparam int NW    = CW + 1;        // exact difference width
    localparam int DVW   = NW + FB;       // scaled dividend width
    localparam int NQ    = CW;            // quotient bits resolved by the divider
    localparam int PW    = 2 * CW;        // product width
    localparam int NFACE = 6;

    // Stage numbering of the pipeline
    localparam int ST_IN   = 0;
    localparam int ST_PREP = 1;
    localparam int ST_DIV0 = 2;
    localparam int ST_T    = ST_DIV0 + NQ + 1;
    localparam int ST_MUL  = ST_T + 1;
    localparam int ST_CHK  = ST_MUL + 1;
    localparam int NST     = ST_CHK + 1;

    // Register indexes
    typedef enum logic [2:0] {
        CFG_X_MIN = 3'd0,
        CFG_Y_MIN = 3'd1,
        CFG_Z_MIN = 3'd2,
        CFG_X_MAX = 3'd3,
        CFG_Y_MAX = 3'd4,
        CFG_Z_MAX = 3'd5
    } t_cfg_idx;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord [2:0]    p;
        t_coord [2:0]    d;
        logic [LW-1:0]   len;
    } t_seg;

    // n-th (0 or 1) of the two axes other than a
    function automatic logic [1:0] other_axis(input logic [1:0] a, input logic n);
        logic [1:0] r;
        unique case (a)
            2'd0:    r = n ? 2'd2 : 2'd1;
            2'd1:    r = n ? 2'd2 : 2'd0;
            default: r = n ? 2'd1 : 2'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/segment_box_face_hit_test.sv
// Segment against axis-aligned box face hit test, fully pipelined.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------
//  segment | in        | i_valid / o_stall   | start_x/y/z, dir_x/y/z, seg_length
//  result  | out       | o_valid / i_stall   | hit
//  config  | in        | i_cfg_we            | i_cfg_index, i_cfg_data
//
// One item enters per cycle while the result is not stalled; the restoring dividers
// have 32 stages (one quotient bit per stage, six dividers side by side, one per face).
// Reset is synchronous and clears all valid bits and the box registers.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
module segment_box_face_hit_test (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [sbfh_pkg::CW-1:0] i_start_x,
    input  logic signed [sbfh_pkg::CW-1:0] i_start_y,
    input  logic signed [sbfh_pkg::CW-1:0] i_start_z,
    input  logic signed [sbfh_pkg::CW-1:0] i_dir_x,
    input  logic signed [sbfh_pkg::CW-1:0] i_dir_y,
    input  logic signed [sbfh_pkg::CW-1:0] i_dir_z,
    input  logic [sbfh_pkg::LW-1:0]     i_seg_length,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_hit,
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_index,
    input  logic [sbfh_pkg::CW-1:0]     i_cfg_data
);

    localparam int CW    = sbfh_pkg::CW;
    localparam int FB    = sbfh_pkg::FB;
    localparam int NW    = sbfh_pkg::NW;
    localparam int DVW   = sbfh_pkg::DVW;
    localparam int NQ    = sbfh_pkg::NQ;
    localparam int PW    = sbfh_pkg::PW;
    localparam int NFACE = sbfh_pkg::NFACE;
    localparam int NST   = sbfh_pkg::NST;

    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [NQ-1:0]        M_MIN = {1'b1, {(NQ-1){1'b0}}};

    // Box registers
    sbfh_pkg::t_coord r_lo [3];
    sbfh_pkg::t_coord r_hi [3];

    // Pipeline control and carried segment
    logic [NST-1:0]     r_vld;
    sbfh_pkg::t_seg     r_seg [NST];
    logic               r_out_vld;
    logic               r_out_hit;
    logic               w_en;

    // Per-face stage registers
    logic [NW-1:0]      r_b_nmag [NFACE];
    logic               r_b_neg  [NFACE];
    logic [CW-1:0]      r_b_dmag [NFACE];

    logic [DVW-1:0]     r_dv_rem  [NQ+1][NFACE];
    logic [NQ-1:0]      r_dv_q    [NQ+1][NFACE];
    logic               r_dv_ovf  [NQ+1][NFACE];
    logic               r_dv_neg  [NQ+1][NFACE];
    logic [CW-1:0]      r_dv_dmag [NQ+1][NFACE];

    logic signed [CW-1:0] r_t    [NFACE];
    logic [NFACE-1:0]     r_t_fv;
    logic signed [PW-1:0] r_prod [NFACE][2];
    logic [NFACE-1:0]     r_m_fv;
    logic [NFACE-1:0]     r_c_hit;

    sbfh_pkg::t_seg w_in_seg;

    assign w_en    = !(r_out_vld && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_out_vld;
    assign o_hit   = r_out_hit;

    always_comb begin
        w_in_seg.p   = {i_start_z, i_start_y, i_start_x};
        w_in_seg.d   = {i_dir_z, i_dir_y, i_dir_x};
        w_in_seg.len = i_seg_length;
    end

    // Configuration writes; out-of-range indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_lo[k] <= '0;
                r_hi[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sbfh_pkg::CFG_X_MIN: r_lo[0] <= i_cfg_data;
                sbfh_pkg::CFG_Y_MIN: r_lo[1] <= i_cfg_data;
                sbfh_pkg::CFG_Z_MIN: r_lo[2] <= i_cfg_data;
                sbfh_pkg::CFG_X_MAX: r_hi[0] <= i_cfg_data;
                sbfh_pkg::CFG_Y_MAX: r_hi[1] <= i_cfg_data;
                sbfh_pkg::CFG_Z_MAX: r_hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[NST-2:0], i_valid};
            r_out_vld <= r_vld[NST-1];
        end
    end

    // Segment carried down the pipe
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_seg[0] <= w_in_seg;
            for (int s = 1; s < NST; s++) r_seg[s] <= r_seg[s-1];
        end
    end

    // Prep: exact difference to the face, magnitudes and quotient sign
    always_ff @(posedge i_clk) begin
        logic [1:0]           a;
        logic signed [CW-1:0] bnd;
        logic signed [CW-1:0] pa;
        logic signed [CW-1:0] da;
        logic [NW-1:0]        num;
        if (w_en) begin
            for (int f = 0; f < NFACE; f++) begin
                a   = 2'(f / 2);
                bnd = (f % 2 == 1) ? r_hi[a] : r_lo[a];
                pa  = r_seg[sbfh_pkg::ST_IN].p[a];
                da  = r_seg[sbfh_pkg::ST_IN].d[a];
                num = {bnd[CW-1], bnd} - {pa[CW-1], pa};
                r_b_nmag[f] <= num[NW-1] ? (~num + NW'(1)) : num;
                r_b_neg[f]  <= num[NW-1] ^ da[CW-1];
                r_b_dmag[f] <= da[CW-1] ? (~da + CW'(1)) : da;
            end
        end
    end

    // Divider entry: overflow when the quotient would need more than NQ bits
    always_ff @(posedge i_clk) begin
        logic [DVW-1:0] dvd;
        if (w_en) begin
            for (int f = 0; f < NFACE; f++) begin
                dvd = {r_b_nmag[f], {FB{1'b0}}};
                r_dv_rem[0][f]  <= dvd;
                r_dv_q[0][f]    <= '0;
                r_dv_ovf[0][f]  <= {{(PW-DVW){1'b0}}, dvd} >= {r_b_dmag[f], {NQ{1'b0}}};
                r_dv_neg[0][f]  <= r_b_neg[f];
                r_dv_dmag[0][f] <= r_b_dmag[f];
            end
        end
    end

    // Restoring divider, one quotient bit per stage, MSB first
    always_ff @(posedge i_clk) begin
        logic [PW-1:0] sub;
        logic [PW-1:0] rem;
        if (w_en) begin
            for (int j = 0; j < NQ; j++) begin
                for (int f = 0; f < NFACE; f++) begin
                    sub = {{(PW-CW){1'b0}}, r_dv_dmag[j][f]} << (NQ - 1 - j);
                    rem = {{(PW-DVW){1'b0}}, r_dv_rem[j][f]};
                    if (rem >= sub) begin
                        r_dv_rem[j+1][f] <= DVW'(rem - sub);
                        r_dv_q[j+1][f]   <= r_dv_q[j][f] | (NQ'(1) << (NQ - 1 - j));
                    end else begin
                        r_dv_rem[j+1][f] <= r_dv_rem[j][f];
                        r_dv_q[j+1][f]   <= r_dv_q[j][f];
                    end
                    r_dv_ovf[j+1][f]  <= r_dv_ovf[j][f];
                    r_dv_neg[j+1][f]  <= r_dv_neg[j][f];
                    r_dv_dmag[j+1][f] <= r_dv_dmag[j][f];
                end
            end
        end
    end

    // Signed, saturated t and the range test 0 < t <= length
    always_ff @(posedge i_clk) begin
        logic signed [CW-1:0] t;
        logic [NQ-1:0]        q;
        logic                 dnz;
        if (w_en) begin
            for (int f = 0; f < NFACE; f++) begin
                q = r_dv_q[NQ][f];
                if (r_dv_neg[NQ][f]) begin
                    if (r_dv_ovf[NQ][f] || q > M_MIN) t = C_MIN;
                    else                                t = -$signed(q);
                end else begin
                    if (r_dv_ovf[NQ][f] || q[NQ-1])   t = C_MAX;
                    else                                t = $signed(q);
                end
                dnz = r_seg[sbfh_pkg::ST_T - 1].d[f/2] != '0;
                r_t[f]    <= t;
                r_t_fv[f] <= dnz && (t > 0) &&
                             (t <= $signed({1'b0, r_seg[sbfh_pkg::ST_T - 1].len}));
            end
        end
    end

    // Products t * dir on the two other axes, 32 by 32 bits signed
    always_ff @(posedge i_clk) begin
        logic signed [CW-1:0] tx;
        logic signed [CW-1:0] dx;
        if (w_en) begin
            for (int f = 0; f < NFACE; f++) begin
                for (int n = 0; n < 2; n++) begin
                    tx = r_t[f];
                    dx = r_seg[sbfh_pkg::ST_T].d[
                        sbfh_pkg::other_axis(2'(f / 2), 1'(n))];
                    r_prod[f][n] <= tx * dx;
                end
            end
            r_m_fv <= r_t_fv;
        end
    end

    // Floor shift, clamp, add start, closed containment on the other axes
    always_ff @(posedge i_clk) begin
        logic signed [PW-1:0] sh;
        logic signed [CW-1:0] cl;
        logic signed [NW-1:0] c;
        logic [1:0]           k;
        logic                 ins;
        if (w_en) begin
            for (int f = 0; f < NFACE; f++) begin
                ins = r_m_fv[f];
                for (int n = 0; n < 2; n++) begin
                    k  = sbfh_pkg::other_axis(2'(f / 2), 1'(n));
                    sh = r_prod[f][n] >>> FB;
                    if (sh > PW'(C_MAX))      cl = C_MAX;
                    else if (sh < PW'(C_MIN)) cl = C_MIN;
                    else                      cl = CW'(sh);
                    c = NW'(r_seg[sbfh_pkg::ST_MUL].p[k]) + NW'(cl);
                    if (c < NW'(r_lo[k]) || c > NW'(r_hi[k])) ins = 1'b0;
                end
                r_c_hit[f] <= ins;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_en) r_out_hit <= |r_c_hit;
    end

    // Assertions
    a_stall_rule: assert property (@(posedge i_clk)
        o_stall == (r_out_vld && i_stall))
        else $error("stall does not follow output occupancy");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |=> $stable(r_vld))
        else $error("pipeline moved while result stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && r_vld == '0))
        else $error("valid bits survive reset");

endmodule

// File: tb/hit_checker.sv
// Checker for the segment box face hit test: tracks the box, predicts and compares hits.
`timescale 1ns / 100ps

module hit_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_stall_up,
    input  logic signed [sbfh_pkg::CW-1:0] i_start_x,
    input  logic signed [sbfh_pkg::CW-1:0] i_start_y,
    input  logic signed [sbfh_pkg::CW-1:0] i_start_z,
    input  logic signed [sbfh_pkg::CW-1:0] i_dir_x,
    input  logic signed [sbfh_pkg::CW-1:0] i_dir_y,
    input  logic signed [sbfh_pkg::CW-1:0] i_dir_z,
    input  logic [sbfh_pkg::LW-1:0]        i_seg_length,
    input  logic                           i_res_valid,
    input  logic                           i_res_stall,
    input  logic                           i_hit,
    input  logic                           i_cfg_we,
    input  logic [2:0]                     i_cfg_index,
    input  logic [sbfh_pkg::CW-1:0]        i_cfg_data,
    output int                             o_fails,
    output int                             o_pending
);

    localparam longint C_MAX = 64'sd2147483647;
    localparam longint C_MIN = -64'sd2147483648;

    // Box limits, index 0..2 = x/y/z
    longint box_lo[3];
    longint box_hi[3];
    bit     hits_due[$];

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint clamp_q(input bit neg, input logic [63:0] m);
        if (neg)
            return (m > 64'd2147483648) ? C_MIN : -longint'(m);
        return (m > 64'd2147483647) ? C_MAX : longint'(m);
    endfunction

    // Fixed-point quotient, truncated toward zero then saturated
    function automatic longint q_div(input longint num, input longint den);
        logic [63:0] q;
        q = (magnitude(num) << sbfh_pkg::FB) / magnitude(den);
        return clamp_q((num < 0) != (den < 0), q);
    endfunction

    // Fixed-point product, floor rounding then saturated
    function automatic longint q_mul(input longint a, input longint b);
        logic [63:0] p;
        logic [63:0] m;
        bit          neg;
        p   = magnitude(a) * magnitude(b);
        neg = (a < 0) != (b < 0);
        m   = neg ? (p + 64'hFFFF) >> sbfh_pkg::FB : p >> sbfh_pkg::FB;
        return clamp_q(neg && m != 0, m);
    endfunction

    function automatic bit face_hit(input longint ps[3], input longint ds[3], input longint len);
        longint bound;
        longint t;
        longint c;
        bit     found;
        bit     ok;
        found = 0;
        for (int a = 0; a < 3; a++) begin
            if (!found && ds[a] != 0) begin
                for (int f = 0; f < 2; f++) begin
                    if (!found) begin
                        bound = f ? box_hi[a] : box_lo[a];
                        t = q_div(bound - ps[a], ds[a]);
                        if (t > 0 && t <= len) begin
                            ok = 1;
                            for (int k = 0; k < 3; k++) begin
                                if (k != a) begin
                                    c = ps[k] + q_mul(t, ds[k]);
                                    if (c < box_lo[k] || c > box_hi[k])
                                        ok = 0;
                                end
                            end
                            found = ok;
                        end
                    end
                end
            end
        end
        return found;
    endfunction

    always @(posedge i_clk) begin
        longint ps[3];
        longint ds[3];
        bit     want;
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                box_lo[k] = 0;
                box_hi[k] = 0;
            end
            hits_due.delete();
            o_fails <= 0;
        end else begin
            // Register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sbfh_pkg::CFG_X_MIN: box_lo[0] = longint'(signed'(i_cfg_data));
                    sbfh_pkg::CFG_Y_MIN: box_lo[1] = longint'(signed'(i_cfg_data));
                    sbfh_pkg::CFG_Z_MIN: box_lo[2] = longint'(signed'(i_cfg_data));
                    sbfh_pkg::CFG_X_MAX: box_hi[0] = longint'(signed'(i_cfg_data));
                    sbfh_pkg::CFG_Y_MAX: box_hi[1] = longint'(signed'(i_cfg_data));
                    sbfh_pkg::CFG_Z_MAX: box_hi[2] = longint'(signed'(i_cfg_data));
                    default: ;
                endcase
            end
            // Accepted segment
            if (i_valid && !i_stall_up) begin
                ps[0] = i_start_x; ps[1] = i_start_y; ps[2] = i_start_z;
                ds[0] = i_dir_x;   ds[1] = i_dir_y;   ds[2] = i_dir_z;
                hits_due.push_back(face_hit(ps, ds, longint'(i_seg_length)));
            end
            // Accepted result
            if (i_res_valid && !i_res_stall) begin
                if (hits_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual hit=%0b",
                             $time, i_hit);
                    o_fails <= o_fails + 1;
                end else begin
                    want = hits_due.pop_front();
                    if (i_hit !== want) begin
                        $display("%0t: hit mismatch, expected %0b, actual %0b",
                                 $time, want, i_hit);
                        o_fails <= o_fails + 1;
                    end
                end
            end
        end
        o_pending <= hits_due.size();
    end

endmodule

// File: tb/tb.sv
// Testbench top for the segment box face hit test: stimulus, box settings and verdict.
`timescale 1ns / 100ps

module tb;

    localparam logic [2:0] CFG_SPARE = 3'd7;   // no register behind this index
    localparam logic [2:0] CFG_GAP   = 3'd6;   // first index past the registers
    localparam int         ONE       = 32'h0001_0000;
    localparam int         LIMIT     = 400000;
    localparam int         DRAIN     = 45;

    logic          i_clk = 0;
    logic          i_rst_n = 0;
    logic          i_valid = 0;
    logic          o_stall;
    sbfh_pkg::t_coord i_start_x = 0, i_start_y = 0, i_start_z = 0;
    sbfh_pkg::t_coord i_dir_x = 0, i_dir_y = 0, i_dir_z = 0;
    logic [sbfh_pkg::LW-1:0] i_seg_length = 0;
    logic          o_valid;
    logic          i_stall = 0;
    logic          o_hit;
    logic          i_cfg_we = 0;
    logic [2:0]    i_cfg_index = 0;
    logic [sbfh_pkg::CW-1:0] i_cfg_data = 0;

    int  fails;
    int  pending;
    int  cycles = 0;
    int  stall_pct = 0;
    bit  gaps_on = 1;
    logic stall_seen;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    segment_box_face_hit_test DUT (.*);

    hit_checker u_check (
        .i_clk, .i_rst_n, .i_valid, .i_stall_up(o_stall),
        .i_start_x, .i_start_y, .i_start_z, .i_dir_x, .i_dir_y, .i_dir_z,
        .i_seg_length, .i_res_valid(o_valid), .i_res_stall(i_stall), .i_hit(o_hit),
        .i_cfg_we, .i_cfg_index, .i_cfg_data, .o_fails(fails), .o_pending(pending)
    );

    // Stall as it stood before the coming edge
    always @(negedge i_clk) stall_seen <= o_stall;

    // Receiver stall pattern, stall level redrawn at random periodically
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles % 300 == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 20;
                2: stall_pct <= 50;
                default: stall_pct <= 85;
            endcase
        end
        i_stall <= ($urandom_range(0, 99) < stall_pct);
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [sbfh_pkg::CW-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 0;
    endtask

    task automatic set_box(input int x0, y0, z0, x1, y1, z1);
        cfg_write(sbfh_pkg::CFG_X_MIN, x0);
        cfg_write(sbfh_pkg::CFG_Y_MIN, y0);
        cfg_write(sbfh_pkg::CFG_Z_MIN, z0);
        cfg_write(sbfh_pkg::CFG_X_MAX, x1);
        cfg_write(sbfh_pkg::CFG_Y_MAX, y1);
        cfg_write(sbfh_pkg::CFG_Z_MAX, z1);
    endtask

    // Drop valid at once, then wait for all hits to come back and the pipe to empty
    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // Drive one segment and hold it until accepted; an optional gap follows
    task automatic send_seg(input int sx, sy, sz, dx, dy, dz, input int len);
        int gap;
        i_valid      <= 1;
        i_start_x    <= sx; i_start_y <= sy; i_start_z <= sz;
        i_dir_x      <= dx; i_dir_y   <= dy; i_dir_z   <= dz;
        i_seg_length <= len[sbfh_pkg::LW-1:0];
        @(posedge i_clk);
        while (stall_seen) @(posedge i_clk);
        gap = 0;
        if (gaps_on && $urandom_range(0, 9) == 0)
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic int pick_dir();
        case ($urandom_range(0, 9))
            0, 1: return 0;
            2:    return ONE;
            3:    return -ONE;
            4:    return 32'h0000_B505;
            5:    return -32'sh0000_B505;
            6:    return $urandom;
            default: return int'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
        endcase
    endfunction

    // Mostly segments near the box, some pure noise
    task automatic random_segs(input int n, input int centre, input int spread);
        int len;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 2) begin
                send_seg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                len = ($urandom_range(0, 19) == 0) ? int'($urandom)
                                                   : int'($urandom_range(0, 32'h0008_0000));
                send_seg(centre + int'($urandom_range(0, 2 * spread)) - spread,
                         centre + int'($urandom_range(0, 2 * spread)) - spread,
                         centre + int'($urandom_range(0, 2 * spread)) - spread,
                         pick_dir(), pick_dir(), pick_dir(), len);
            end
            if (i % 60 == 59) gaps_on = !gaps_on;
        end
    endtask

    initial begin
        int r0, r1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;

        // Reset box (all zero) sees a few segments first
        send_seg(-ONE, 0, 0, ONE, 0, 0, 2 * ONE);
        send_seg(0, 0, 0, 0, 0, 0, 5 * ONE);
        drain();

        // Unit box, directed cases
        set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
        send_seg(-2 * ONE, 0, 0, ONE, 0, 0, 4 * ONE);      // through x min
        send_seg(2 * ONE, 0, 0, -ONE, 0, 0, 4 * ONE);      // through x max
        send_seg(0, -2 * ONE, 0, 0, ONE, 0, 4 * ONE);      // y min
        send_seg(0, 2 * ONE, 0, 0, -ONE, 0, 4 * ONE);      // y max
        send_seg(0, 0, -2 * ONE, 0, 0, ONE, 4 * ONE);      // z min
        send_seg(0, 0, 2 * ONE, 0, 0, -ONE, 4 * ONE);      // z max
        send_seg(0, 0, 0, 0, 0, 0, 4 * ONE);               // all directions zero
        send_seg(0, 0, 0, ONE >>> 4, 0, 0, ONE >>> 8);     // wholly inside
        send_seg(-2 * ONE, 0, 0, ONE, 0, 0, ONE);          // t exactly the length
        send_seg(-2 * ONE, 0, 0, ONE, 0, 0, ONE - 1);      // just short
        send_seg(-2 * ONE, 0, 0, ONE, 0, 0, 0);            // zero length
        send_seg(-2 * ONE, ONE, ONE, ONE, 0, 0, 4 * ONE);  // grazes an edge
        send_seg(-2 * ONE, 0, 0, -ONE, 0, 0, 4 * ONE);     // pointing away
        send_seg(-2 * ONE, -2 * ONE, 0, 32'h0000_B505, 32'h0000_B505, 0, 8 * ONE);
        send_seg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_seg(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_seg(-2 * ONE, 0, 0, 1, 0, 0, 32'h7FFF_FFFF);  // tiny direction
        send_seg(32'h8000_0000, 0, 0, 1, 32'h8000_0000, 1, 32'h7FFF_FFFF);
        send_seg(-2 * ONE, 0, 0, 2 * ONE, ONE, 0, 4 * ONE); // non-unit direction
        random_segs(240, 0, 3 * ONE);
        drain();

        // Out-of-range index must leave the box alone
        cfg_write(CFG_SPARE, 32'h1234_5678);
        cfg_write(CFG_GAP, 32'hFFFF_FFFF);
        random_segs(60, 0, 3 * ONE);
        drain();

        // Random small box off centre
        r0 = int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
        r1 = r0 + int'($urandom_range(ONE / 4, 3 * ONE));
        set_box(r0, r0 - ONE, r0 + ONE / 2, r1, r1 + ONE, r1);
        random_segs(220, r0 + (r1 - r0) / 2, 4 * ONE);
        drain();

        // Box inverted on x and z
        set_box(ONE, -ONE, ONE, -ONE, ONE, -ONE);
        random_segs(200, 0, 3 * ONE);
        drain();

        // Full range box
        set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        random_segs(220, 0, 32'h4000_0000);
        drain();

        // Random wide box
        r0 = $urandom; r1 = $urandom;
        set_box(r0 < r1 ? r0 : r1, -int'($urandom_range(0, 32'h1000_0000)), 32'h8000_0000,
                r0 < r1 ? r1 : r0, int'($urandom_range(0, 32'h1000_0000)), 32'h0);
        random_segs(220, 0, 32'h1000_0000);
        drain();

        // Degenerate flat box
        set_box(0, -ONE, -ONE, 0, ONE, ONE);
        random_segs(250, 0, 2 * ONE);
        drain();

        if (fails == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
